FILE: hdl/frc_pkg.sv
package frc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_OUT
    } frc_state_t;

    // Sequencing of one binary GCD run
    typedef enum logic [1:0] {
        GP_IDLE,
        GP_COMMON,
        GP_LOOP
    } gcd_phase_t;

endpackage

FILE: hdl/fraction_reduce.sv
// fraction_reduce: takes one signed numerator and denominator per input beat
// and returns one result beat holding the fraction in lowest terms. Both
// magnitudes are divided by their greatest common divisor and each value keeps
// the sign it arrived with. A zero numerator gives 0 over +1 or -1 following
// the denominator's sign; a zero denominator sets zero_denominator and passes
// the pair through. One item is worked at a time and s_ready is low until its
// result beat has been taken. A zero input goes straight to the result beat,
// which then waits on m_ready; otherwise the item runs a binary GCD (one shift
// or one subtract per cycle) followed by two restoring divisions through one
// shared divider, and the result beat then waits on m_ready.
module fraction_reduce #(
    parameter int WORD_BITS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [WORD_BITS-1:0] s_numerator,
    input  logic signed [WORD_BITS-1:0] s_denominator,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [WORD_BITS-1:0] m_reduced_numerator,
    output logic signed [WORD_BITS-1:0] m_reduced_denominator,
    output logic                        m_zero_denominator
);
    import frc_pkg::*;

    frc_state_t           state_reg, state_next;

    // magnitudes and signs of the beat in flight
    logic [WORD_BITS-1:0] mn_reg, mn_next;
    logic [WORD_BITS-1:0] md_reg, md_next;
    logic                 nneg_reg, nneg_next;
    logic                 dneg_reg, dneg_next;
    logic [WORD_BITS-1:0] g_reg, g_next;
    logic [WORD_BITS-1:0] rn_reg, rn_next;

    // result registers
    logic [WORD_BITS-1:0] out_num_reg, out_num_next;
    logic [WORD_BITS-1:0] out_den_reg, out_den_next;
    logic                 out_zd_reg, out_zd_next;

    logic                 gcd_start, gcd_done;
    logic [WORD_BITS-1:0] gcd_result;
    logic                 div_start, div_done;
    logic [WORD_BITS-1:0] div_dividend, div_divisor, div_quotient;

    logic [WORD_BITS-1:0] in_num, in_den;

    assign in_num = s_numerator;
    assign in_den = s_denominator;

    frc_gcd #(.WORD_BITS(WORD_BITS)) u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gcd_start),
        .op_a    (mn_reg),
        .op_b    (md_reg),
        .done    (gcd_done),
        .result  (gcd_result)
    );

    // The divider is shared: numerator first, then denominator
    assign div_dividend = (state_reg == ST_GCD) ? mn_reg : md_reg;
    assign div_divisor  = (state_reg == ST_GCD) ? gcd_result : g_reg;

    frc_div #(.WORD_BITS(WORD_BITS)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next   = state_reg;
        mn_next      = mn_reg;
        md_next      = md_reg;
        nneg_next    = nneg_reg;
        dneg_next    = dneg_reg;
        g_next       = g_reg;
        rn_next      = rn_reg;
        out_num_next = out_num_reg;
        out_den_next = out_den_reg;
        out_zd_next  = out_zd_reg;
        gcd_start    = 1'b0;
        div_start    = 1'b0;
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                nneg_next = in_num[WORD_BITS-1];
                dneg_next = in_den[WORD_BITS-1];
                mn_next   = in_num[WORD_BITS-1] ? (~in_num + 1'b1) : in_num;
                md_next   = in_den[WORD_BITS-1] ? (~in_den + 1'b1) : in_den;
                if (s_valid) begin
                    if (in_den == '0) begin
                        // pass the pair through and flag it
                        out_num_next = in_num;
                        out_den_next = in_den;
                        out_zd_next  = 1'b1;
                        state_next   = ST_OUT;
                    end else if (in_num == '0) begin
                        out_num_next = '0;
                        out_den_next = in_den[WORD_BITS-1] ? '1 : WORD_BITS'(1);
                        out_zd_next  = 1'b0;
                        state_next   = ST_OUT;
                    end else begin
                        state_next = ST_GCD;
                    end
                end
            end
            ST_GCD: begin
                // launch GCD on the first cycle here, wait for it to finish
                gcd_start = (g_reg == '0);
                g_next    = '1;
                if (gcd_done) begin
                    g_next     = gcd_result;
                    div_start  = 1'b1;
                    state_next = ST_DIV_NUM;
                end
            end
            ST_DIV_NUM: begin
                if (div_done) begin
                    rn_next    = div_quotient;
                    div_start  = 1'b1;
                    state_next = ST_DIV_DEN;
                end
            end
            ST_DIV_DEN: begin
                if (div_done) begin
                    out_num_next = nneg_reg ? (~rn_reg + 1'b1) : rn_reg;
                    out_den_next = dneg_reg ? (~div_quotient + 1'b1) : div_quotient;
                    out_zd_next  = 1'b0;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold the result until the beat is taken
                m_valid = 1'b1;
                g_next  = '0;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            g_reg     <= '0;
        end else begin
            state_reg <= state_next;
            g_reg     <= g_next;
        end
        mn_reg      <= mn_next;
        md_reg      <= md_next;
        nneg_reg    <= nneg_next;
        dneg_reg    <= dneg_next;
        rn_reg      <= rn_next;
        out_num_reg <= out_num_next;
        out_den_reg <= out_den_next;
        out_zd_reg  <= out_zd_next;
    end

    assign m_reduced_numerator   = out_num_reg;
    assign m_reduced_denominator = out_den_reg;
    assign m_zero_denominator    = out_zd_reg;

endmodule

FILE: hdl/frc_gcd.sv
module frc_gcd #(
    parameter int WORD_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] op_a,
    input  logic [WORD_BITS-1:0] op_b,
    output logic                 done,
    output logic [WORD_BITS-1:0] result
);
    import frc_pkg::*;

    localparam int SHIFT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    gcd_phase_t            phase_reg, phase_next;
    logic [WORD_BITS-1:0]  a_reg, a_next;
    logic [WORD_BITS-1:0]  b_reg, b_next;
    logic [SHIFT_BITS-1:0] shift_reg, shift_next;
    logic                  done_reg, done_next;
    logic [WORD_BITS-1:0]  result_reg, result_next;

    // One binary GCD step per cycle: one shift, or one compare and subtract
    always_comb begin
        phase_next  = phase_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        shift_next  = shift_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (phase_reg)
            GP_IDLE: begin
                if (start) begin
                    a_next     = op_a;
                    b_next     = op_b;
                    shift_next = '0;
                    phase_next = GP_COMMON;
                end
            end
            GP_COMMON: begin
                // strip factors of two common to both
                if (a_reg[0] == 1'b0 && b_reg[0] == 1'b0) begin
                    a_next     = a_reg >> 1;
                    b_next     = b_reg >> 1;
                    shift_next = shift_reg + 1'b1;
                end else begin
                    phase_next = GP_LOOP;
                end
            end
            GP_LOOP: begin
                if (a_reg[0] == 1'b0) begin
                    a_next = a_reg >> 1;
                end else if (b_reg == '0) begin
                    result_next = a_reg << shift_reg;
                    done_next   = 1'b1;
                    phase_next  = GP_IDLE;
                end else if (b_reg[0] == 1'b0) begin
                    b_next = b_reg >> 1;
                end else if (a_reg > b_reg) begin
                    a_next = b_reg;
                    b_next = a_reg - b_reg;
                end else begin
                    b_next = b_reg - a_reg;
                end
            end
            default: begin
                phase_next = GP_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= GP_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        a_reg      <= a_next;
        b_reg      <= b_next;
        shift_reg  <= shift_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hdl/frc_div.sv
module frc_div #(
    parameter int WORD_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] dividend,
    input  logic [WORD_BITS-1:0] divisor,
    output logic                 done,
    output logic [WORD_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [WORD_BITS:0]   rem_reg, rem_next;
    logic [WORD_BITS-1:0] quo_reg, quo_next;
    logic [WORD_BITS-1:0] dsr_reg, dsr_next;
    logic [WORD_BITS:0]   rem_shift;

    // Restoring division, one quotient bit per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        rem_shift = {rem_reg[WORD_BITS-1:0], quo_reg[WORD_BITS-1]};
        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1;
                cnt_next  = CNT_BITS'(WORD_BITS);
                rem_next  = '0;
                quo_next  = dividend;
                dsr_next  = divisor;
            end
        end else begin
            if (rem_shift >= {1'b0, dsr_reg}) begin
                rem_next = rem_shift - {1'b0, dsr_reg};
                quo_next = {quo_reg[WORD_BITS-2:0], 1'b1};
            end else begin
                rem_next = rem_shift;
                quo_next = {quo_reg[WORD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
